### hdl/assert_macros.svh
// Shared assertion macros for the fingerprint accumulator checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/simh_pkg.sv
package simh_pkg;

  localparam int HASH_BITS        = 32;
  localparam int WEIGHT_FRAC_BITS = 16;

  localparam int ID_W     = 32;
  localparam int WEIGHT_W = 32;
  localparam int FP_W     = 32;
  localparam int ACC_W    = 32;
  localparam int DIFF_W   = ACC_W + 1;
  localparam int SUM_W    = ACC_W + 2;

  localparam logic [DIFF_W-1:0] FRAC_MASK =
    DIFF_W'((64'd1 << WEIGHT_FRAC_BITS) - 64'd1);

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

  typedef struct packed {
    logic upd;
    logic clr;
  } lane_ctrl_t;

endpackage

### hdl/simhash_fingerprint_accumulator_core.sv
// SimHash fingerprint accumulator. One feature beat (feature_id, weight,
// last) is taken every clock cycle while feature_stall is low, since all
// accumulator lanes update in parallel; each lane adds or subtracts the
// fixed-point weight and truncates the sum toward zero, with saturation to
// 32 bits. The beat marked last produces one fingerprint beat, registered
// in the fingerprint register once that beat has moved through the input
// register, and the accumulators start the next document at zero with no
// gap. The input register stalls only when a finished fingerprint is still
// held by a stalled output and another last beat is waiting to complete.
module simhash_fingerprint_accumulator_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 feature_valid,
  output logic                                 feature_stall,
  input  logic [simh_pkg::ID_W-1:0]            feature_id,
  input  logic signed [simh_pkg::WEIGHT_W-1:0] weight,
  input  logic                                 last,
  output logic                                 hash_valid,
  input  logic                                 hash_stall,
  output logic [simh_pkg::FP_W-1:0]            fingerprint
);

  logic                                 s1_valid;
  logic [simh_pkg::ID_W-1:0]            s1_id;
  logic signed [simh_pkg::WEIGHT_W-1:0] s1_weight;
  logic                                 s1_last;
  logic                                 s1_move;
  logic                                 accept;
  simh_pkg::lane_ctrl_t                 lane_ctrl;
  logic [simh_pkg::HASH_BITS-1:0]       nonneg;
  logic [simh_pkg::FP_W-1:0]            fingerprint_next;

  assign feature_stall = s1_valid && s1_last && hash_valid && hash_stall;
  assign s1_move       = s1_valid && !feature_stall;
  assign accept        = feature_valid && !feature_stall;

  assign lane_ctrl.upd = s1_move;
  assign lane_ctrl.clr = s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!feature_stall) begin
      s1_valid <= feature_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_id     <= feature_id;
      s1_weight <= weight;
      s1_last   <= last;
    end
  end

  for (genvar i = 0; i < simh_pkg::HASH_BITS; i++) begin : g_lane
    logic hash_bit;
    if (i < simh_pkg::ID_W) begin : g_id
      assign hash_bit = s1_id[i];
    end else begin : g_zero
      assign hash_bit = 1'b0;
    end
    simh_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (lane_ctrl),
      .hash_bit (hash_bit),
      .weight   (s1_weight),
      .nonneg   (nonneg[i])
    );
  end

  for (genvar j = 0; j < simh_pkg::FP_W; j++) begin : g_fp
    if (j < simh_pkg::HASH_BITS) begin : g_bit
      assign fingerprint_next[j] = nonneg[j];
    end else begin : g_pad
      assign fingerprint_next[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (s1_move && s1_last) begin
      hash_valid <= 1'b1;
    end else if (!hash_stall) begin
      hash_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_last) begin
      fingerprint <= fingerprint_next;
    end
  end

endmodule

### hdl/simh_lane.sv
module simh_lane (
  input  logic                                    clk,
  input  logic                                    rst,
  input  simh_pkg::lane_ctrl_t                    ctrl,
  input  logic                                    hash_bit,
  input  logic signed [simh_pkg::WEIGHT_W-1:0]    weight,
  output logic                                    nonneg
);

  logic signed [simh_pkg::ACC_W-1:0]  acc;
  logic signed [simh_pkg::ACC_W-1:0]  acc_next;
  logic signed [simh_pkg::DIFF_W-1:0] wext;
  logic signed [simh_pkg::DIFF_W-1:0] delta;
  logic signed [simh_pkg::DIFF_W-1:0] quot;
  logic signed [simh_pkg::SUM_W-1:0]  sum;
  logic signed [simh_pkg::SUM_W-1:0]  trunc;
  logic                               round_up;

  // The accumulator is an integer, so the fraction of the weight only
  // matters for rounding a negative result toward zero.
  always_comb begin
    wext     = {weight[simh_pkg::WEIGHT_W-1], weight};
    delta    = hash_bit ? wext : -wext;
    quot     = delta >>> simh_pkg::WEIGHT_FRAC_BITS;
    sum      = {{2{acc[simh_pkg::ACC_W-1]}}, acc} + {quot[simh_pkg::DIFF_W-1], quot};
    round_up = sum[simh_pkg::SUM_W-1] && ((delta & simh_pkg::FRAC_MASK) != '0);
    trunc    = sum + {{(simh_pkg::SUM_W-1){1'b0}}, round_up};
    if (trunc > simh_pkg::SAT_HI) begin
      acc_next = simh_pkg::SAT_HI[simh_pkg::ACC_W-1:0];
    end else if (trunc < simh_pkg::SAT_LO) begin
      acc_next = simh_pkg::SAT_LO[simh_pkg::ACC_W-1:0];
    end else begin
      acc_next = trunc[simh_pkg::ACC_W-1:0];
    end
  end

  assign nonneg = !acc_next[simh_pkg::ACC_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.upd) begin
      acc <= ctrl.clr ? '0 : acc_next;
    end
  end

endmodule

### hdl/simh_checker.sv
`include "assert_macros.svh"

module simh_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      feature_valid,
  input logic                      feature_stall,
  input logic                      last,
  input logic                      hash_valid,
  input logic                      hash_stall,
  input logic [simh_pkg::FP_W-1:0] fingerprint
);

  logic last_beat;

  assign last_beat = feature_valid && !feature_stall && last;

  `ASSERT_NEXT(a_out_hold, clk, rst, hash_valid && hash_stall,
               hash_valid && $stable(fingerprint))
  `ASSERT_SAME(a_stall_cause, clk, rst, feature_stall, hash_valid && hash_stall)
  `ASSERT_SAME(a_out_origin, clk, rst, $rose(hash_valid), $past(last_beat, 2))

endmodule

bind simhash_fingerprint_accumulator_core simh_checker u_simh_checker (.*);
